### rtl/ppmsp_pkg.sv
package ppmsp_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // error codes
   localparam logic [3:0] ST_NONE        = 4'd0;
   localparam logic [3:0] ST_BAD_FIRST   = 4'd1;
   localparam logic [3:0] ST_BAD_TYPE    = 4'd2;
   localparam logic [3:0] ST_NO_SEP      = 4'd3;
   localparam logic [3:0] ST_PREMATURE   = 4'd4;
   localparam logic [3:0] ST_NO_NUMBER   = 4'd5;
   localparam logic [3:0] ST_BAD_DIM     = 4'd6;
   localparam logic [3:0] ST_BAD_MAXVAL  = 4'd7;
   localparam logic [3:0] ST_BAD_SAMPLE  = 4'd8;
   localparam logic [3:0] ST_NO_PIXELS   = 4'd9;
   localparam logic [3:0] ST_EXTRA_DATA  = 4'd10;
   localparam logic [3:0] ST_BAD_CHAR    = 4'd11;

   // characters
   localparam logic [7:0] CH_P       = 8'h50;
   localparam logic [7:0] CH_THREE   = 8'h33;
   localparam logic [7:0] CH_SIX     = 8'h36;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [9:0] {
      PH_MAGIC    = 10'b00_0000_0001,
      PH_TYPE     = 10'b00_0000_0010,
      PH_SEP      = 10'b00_0000_0100,
      PH_SKIP     = 10'b00_0000_1000,
      PH_COMMENT  = 10'b00_0001_0000,
      PH_HNUM     = 10'b00_0010_0000,
      PH_TEXT     = 10'b00_0100_0000,
      PH_RAW      = 10'b00_1000_0000,
      PH_COMPLETE = 10'b01_0000_0000,
      PH_DISCARD  = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  status;
      logic        is_binary;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  max_value;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        final_result;
   } rsp_type;

endpackage

### rtl/ppmsp_rsp_queue.sv
module ppmsp_rsp_queue
   import ppmsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push0,
   input  logic    push1,
   input  rsp_type entry0,
   input  rsp_type entry1,
   output logic    room,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_entry
);

   rsp_type    mem [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // room for the two results one item can cause
   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_entry = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // advance pointers and count
   always_comb begin
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      wr_ptr_in = wr_ptr_ff + 2'(push0) + 2'(push1);
      count_in  = count_ff + 3'(push0) + 3'(push1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store results
   always_ff @(posedge clock) begin
      if (push0) begin
         mem[wr_ptr_ff] <= entry0;
      end
      if (push1) begin
         mem[wr_ptr_ff + 2'd1] <= entry1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("queue count overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push0 |-> room) else $error("push without room");
   a_second_push: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0) else $error("second result without first");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop |=> (count_ff == $past(count_ff) - 3'd1 + 3'($past(push0))
               + 3'($past(push1)))) else $error("count mismatch on pop");

endmodule

### rtl/ppm_stream_parser_top.sv
// PPM stream parser: takes a P3 or P6 file one byte per accepted item and
// returns a header result, one result per pixel, and a complete result on the
// byte marked end_of_file, or an error result on the byte where the error is
// found. A byte is taken every cycle while the four-entry result queue has two
// free slots; a byte that causes two results fills two queue slots, so the
// sustained rate is one byte per cycle when the result side keeps up, limited
// by output drain otherwise. Results are registered in the queue before output.
module ppm_stream_parser_top
   import ppmsp_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_status,
   output logic        rsp_is_binary,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [7:0]  rsp_max_value,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_final_result
);

   localparam int AccW  = (DIM_BITS + 1 > 10) ? DIM_BITS + 1 : 10;
   localparam logic [AccW-1:0] AccSat = AccW'(1) << DIM_BITS;

   phase_type           phase_ff, phase_in;
   logic                binary_ff, binary_in;
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [7:0]          maxval_ff, maxval_in;
   logic [AccW-1:0]     acc_ff, acc_in;
   logic [2:0]          digits_ff, digits_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [1:0]          sidx_ff, sidx_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;

   logic       accept, room;
   logic       is_sp, is_dg;
   logic [7:0] dval;
   logic       tok_main, tok_end, samp;
   logic [AccW-1:0] tok_v, field_v;
   logic [AccW+3:0] acc_wide;
   logic [7:0] samp_v;
   logic [DIM_BITS:0] col_next, row_next;
   logic [31:0] wd32, ht32;
   logic       p0, p1;
   rsp_type    e0, e1, out_e;

   assign accept    = req_valid && req_ready;
   assign req_ready = room;

   assign is_sp = (req_data_byte == CH_SPACE) ||
                  ((req_data_byte >= CH_TAB) && (req_data_byte <= CH_CR));
   assign is_dg = (req_data_byte >= CH_ZERO) && (req_data_byte <= CH_NINE);
   assign dval  = req_data_byte - CH_ZERO;

   // next state and results for one byte
   always_comb begin
      phase_in  = phase_ff;
      binary_in = binary_ff;
      width_in  = width_ff;
      height_in = height_ff;
      maxval_in = maxval_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      sidx_in   = sidx_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      p0 = 1'b0;
      p1 = 1'b0;
      e0 = '0;
      e1 = '0;
      tok_main = 1'b0;
      tok_end  = 1'b0;
      samp     = 1'b0;
      samp_v   = '0;
      tok_v    = '0;
      field_v  = '0;
      acc_wide = '0;
      col_next = '0;
      row_next = '0;
      wd32 = '0;
      ht32 = '0;

      unique case (phase_ff)
         PH_MAGIC: begin
            if (req_data_byte == CH_P) begin
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_BAD_FIRST;
            end
         end
         PH_TYPE: begin
            if (req_data_byte == CH_THREE) begin
               binary_in = 1'b0; phase_in = PH_SEP;
            end else if (req_data_byte == CH_SIX) begin
               binary_in = 1'b1; phase_in = PH_SEP;
            end else begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_BAD_TYPE;
            end
         end
         PH_SEP: begin
            if (is_sp) begin
               sidx_in = 2'd0; phase_in = PH_SKIP;
            end else begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_NO_SEP;
            end
         end
         PH_SKIP: begin
            if (is_sp) begin
               phase_in = PH_SKIP;
            end else if (req_data_byte == CH_HASH) begin
               phase_in = PH_COMMENT;
            end else if (is_dg) begin
               acc_in = AccW'(dval[3:0]);
               if (sidx_ff != 2'd3) begin
                  phase_in = PH_HNUM;
               end else begin
                  sidx_in = 2'd0; digits_in = 3'd1; phase_in = PH_TEXT;
               end
            end else begin
               phase_in = PH_DISCARD; p0 = 1'b1; e0.kind = KIND_ERROR;
               e0.status = (sidx_ff != 2'd3) ? ST_NO_NUMBER : ST_BAD_CHAR;
            end
         end
         PH_COMMENT: begin
            if (req_data_byte == CH_NEWLINE) begin
               phase_in = PH_SKIP;
            end
         end
         PH_HNUM: begin
            if (is_dg) begin
               acc_wide = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                        + (AccW+4)'(dval[3:0]);
               acc_in = (acc_wide > (AccW+4)'(AccSat)) ? AccSat
                                                         : acc_wide[AccW-1:0];
            end else if (is_sp) begin
               // close a header field
               field_v = acc_ff;
               acc_in  = '0;
               case (sidx_ff)
                  2'd0: begin
                     if (field_v == '0 || field_v == AccSat) begin
                        phase_in = PH_DISCARD; p0 = 1'b1;
                        e0.kind = KIND_ERROR; e0.status = ST_BAD_DIM;
                     end else begin
                        width_in = field_v[DIM_BITS-1:0];
                        sidx_in = 2'd1; phase_in = PH_SKIP;
                     end
                  end
                  2'd1: begin
                     if (field_v == AccSat) begin
                        phase_in = PH_DISCARD; p0 = 1'b1;
                        e0.kind = KIND_ERROR; e0.status = ST_BAD_DIM;
                     end else begin
                        height_in = field_v[DIM_BITS-1:0];
                        sidx_in = 2'd2; phase_in = PH_SKIP;
                     end
                  end
                  2'd2: begin
                     if (field_v > AccW'(255)) begin
                        phase_in = PH_DISCARD; p0 = 1'b1;
                        e0.kind = KIND_ERROR; e0.status = ST_BAD_MAXVAL;
                     end else begin
                        maxval_in = field_v[7:0];
                        p0 = 1'b1; e0.kind = KIND_HEADER;
                        if (height_ff == '0) begin
                           sidx_in = 2'd0; phase_in = PH_COMPLETE;
                        end else if (binary_ff) begin
                           sidx_in = 2'd0; phase_in = PH_RAW;
                        end else begin
                           sidx_in = 2'd3; phase_in = PH_SKIP;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_DISCARD; p0 = 1'b1;
                     e0.kind = KIND_ERROR; e0.status = ST_NO_NUMBER;
                  end
               endcase
            end else begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_NO_SEP;
            end
         end
         PH_TEXT: begin
            if (is_dg) begin
               if (digits_ff >= 3'd3) begin
                  phase_in = PH_DISCARD; p0 = 1'b1;
                  e0.kind = KIND_ERROR; e0.status = ST_BAD_SAMPLE;
               end else begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + AccW'(dval[3:0]);
                  digits_in = digits_ff + 3'd1;
               end
            end else if (is_sp) begin
               tok_main = (digits_ff != 3'd0);
            end else begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_BAD_CHAR;
            end
         end
         PH_RAW: begin
            if (req_data_byte > maxval_ff) begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_BAD_SAMPLE;
            end else begin
               samp = 1'b1; samp_v = req_data_byte;
            end
         end
         PH_COMPLETE: begin
            if (binary_ff || !is_sp) begin
               phase_in = PH_DISCARD; p0 = 1'b1;
               e0.kind = KIND_ERROR; e0.status = ST_EXTRA_DATA;
            end
         end
         PH_DISCARD: begin
            phase_in = PH_DISCARD;
         end
         default: begin
            phase_in = PH_DISCARD;
         end
      endcase

      // end a text token, by whitespace or by end of file
      tok_end = tok_main || (req_end_of_file && phase_in == PH_TEXT &&
                             digits_in != 3'd0);
      if (tok_end) begin
         tok_v = acc_in;
         acc_in = '0;
         digits_in = 3'd0;
         if (tok_v > AccW'(maxval_in)) begin
            phase_in = PH_DISCARD;
            if (!p0) begin
               p0 = 1'b1; e0.kind = KIND_ERROR; e0.status = ST_BAD_SAMPLE;
            end else begin
               p1 = 1'b1; e1.kind = KIND_ERROR; e1.status = ST_BAD_SAMPLE;
            end
         end else begin
            samp = 1'b1; samp_v = tok_v[7:0];
         end
      end

      // collect samples into pixels
      if (samp) begin
         if (sidx_in == 2'd0) begin
            red_in = samp_v; sidx_in = 2'd1;
         end else if (sidx_in == 2'd1) begin
            green_in = samp_v; sidx_in = 2'd2;
         end else begin
            if (!p0) begin
               p0 = 1'b1; e0.kind = KIND_PIXEL;
               e0.red = red_in; e0.green = green_in; e0.blue = samp_v;
            end else begin
               p1 = 1'b1; e1.kind = KIND_PIXEL;
               e1.red = red_in; e1.green = green_in; e1.blue = samp_v;
            end
            sidx_in = 2'd0;
            col_next = {1'b0, col_in} + 1'b1;
            if (col_next >= {1'b0, width_in}) begin
               col_in = '0;
               row_next = {1'b0, row_in} + 1'b1;
               row_in = row_next[DIM_BITS-1:0];
               if (row_next >= {1'b0, height_in}) begin
                  phase_in = PH_COMPLETE;
               end
            end else begin
               col_in = col_next[DIM_BITS-1:0];
            end
         end
      end

      // report at end of file
      if (req_end_of_file) begin
         if (phase_in == PH_COMPLETE) begin
            if (!p0) begin
               p0 = 1'b1; e0.kind = KIND_DONE;
            end else begin
               p1 = 1'b1; e1.kind = KIND_DONE;
            end
         end else if (phase_in == PH_TEXT || phase_in == PH_RAW ||
                      (phase_in == PH_SKIP && sidx_in == 2'd3)) begin
            if (!p0) begin
               p0 = 1'b1; e0.kind = KIND_ERROR; e0.status = ST_NO_PIXELS;
            end else begin
               p1 = 1'b1; e1.kind = KIND_ERROR; e1.status = ST_NO_PIXELS;
            end
         end else if (phase_in != PH_DISCARD) begin
            if (!p0) begin
               p0 = 1'b1; e0.kind = KIND_ERROR; e0.status = ST_PREMATURE;
            end else begin
               p1 = 1'b1; e1.kind = KIND_ERROR; e1.status = ST_PREMATURE;
            end
         end
      end

      // header fields as held after this byte
      wd32 = 32'(width_in);
      ht32 = 32'(height_in);
      e0.is_binary = binary_in;  e1.is_binary = binary_in;
      e0.image_width = wd32[15:0];  e1.image_width = wd32[15:0];
      e0.image_height = ht32[15:0]; e1.image_height = ht32[15:0];
      e0.max_value = maxval_in;  e1.max_value = maxval_in;
      e0.final_result = p0 && !p1;
      e1.final_result = p1;

      // restart for the next file
      if (req_end_of_file) begin
         phase_in  = PH_MAGIC;
         binary_in = 1'b0;
         width_in  = '0;
         height_in = '0;
         maxval_in = '0;
         acc_in    = '0;
         digits_in = '0;
         col_in    = '0;
         row_in    = '0;
         sidx_in   = '0;
         red_in    = '0;
         green_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         binary_ff <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         maxval_ff <= '0;
         acc_ff    <= '0;
         digits_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         sidx_ff   <= '0;
         red_ff    <= '0;
         green_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         binary_ff <= binary_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         sidx_ff   <= sidx_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
      end
   end

   ppmsp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (accept && p0),
      .push1     (accept && p1),
      .entry0    (e0),
      .entry1    (e1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_entry (out_e)
   );

   assign rsp_kind         = out_e.kind;
   assign rsp_status       = out_e.status;
   assign rsp_is_binary    = out_e.is_binary;
   assign rsp_image_width  = out_e.image_width;
   assign rsp_image_height = out_e.image_height;
   assign rsp_max_value    = out_e.max_value;
   assign rsp_red          = out_e.red;
   assign rsp_green        = out_e.green;
   assign rsp_blue         = out_e.blue;
   assign rsp_final_result = out_e.final_result;

endmodule
